@@ rtl/vector_complex_quaternion_alu_macros.svh @@
// Assertion helpers; clocked on clk_i, idle while rst_ni is low.
`ifndef VECTOR_COMPLEX_QUATERNION_ALU_MACROS_SVH
`define VECTOR_COMPLEX_QUATERNION_ALU_MACROS_SVH

// Same-cycle implication.
`define VCQ_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("vcq assertion failed");

// Next-cycle implication.
`define VCQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("vcq assertion failed");

`endif

@@ rtl/vcq_pkg.sv @@
package vcq_pkg;

  localparam int LANES = 4;
  localparam int TERMS = 4;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] KIND_CPLX = 3'd0;
  localparam logic [2:0] KIND_VEC2 = 3'd1;
  localparam logic [2:0] KIND_VEC3 = 3'd2;
  localparam logic [2:0] KIND_VEC4 = 3'd3;
  localparam logic [2:0] KIND_QUAT = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_KIND = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  typedef enum logic [3:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_CMUL,
    MODE_CDIV,
    MODE_VMUL,
    MODE_VDIV,
    MODE_QMUL,
    MODE_QDIV,
    MODE_BAD
  } mode_e;

  // One product term of a lane: +/- a[ai] * b[bi]
  typedef struct packed {
    logic       used;
    logic [1:0] ai;
    logic [1:0] bi;
    logic       neg;
  } term_t;

  typedef struct packed {
    mode_e            mode;
    logic [LANES-1:0] used;
    logic             bad;
    logic             dz;
  } ctrl_t;

  localparam term_t T_NONE = '{1'b0, 2'd0, 2'd0, 1'b0};

  localparam term_t CMUL_TAB [LANES][TERMS] = '{
    '{'{1'b1, 2'd0, 2'd0, 1'b0}, '{1'b1, 2'd1, 2'd1, 1'b1}, T_NONE, T_NONE},
    '{'{1'b1, 2'd0, 2'd1, 1'b0}, '{1'b1, 2'd1, 2'd0, 1'b0}, T_NONE, T_NONE},
    '{T_NONE, T_NONE, T_NONE, T_NONE},
    '{T_NONE, T_NONE, T_NONE, T_NONE}
  };

  // a * conj(b) numerator
  localparam term_t CDIV_TAB [LANES][TERMS] = '{
    '{'{1'b1, 2'd0, 2'd0, 1'b0}, '{1'b1, 2'd1, 2'd1, 1'b0}, T_NONE, T_NONE},
    '{'{1'b1, 2'd1, 2'd0, 1'b0}, '{1'b1, 2'd0, 2'd1, 1'b1}, T_NONE, T_NONE},
    '{T_NONE, T_NONE, T_NONE, T_NONE},
    '{T_NONE, T_NONE, T_NONE, T_NONE}
  };

  // Hamilton product, index 3 is the scalar part
  localparam term_t HAM_TAB [LANES][TERMS] = '{
    '{'{1'b1, 2'd3, 2'd0, 1'b0}, '{1'b1, 2'd0, 2'd3, 1'b0},
      '{1'b1, 2'd1, 2'd2, 1'b0}, '{1'b1, 2'd2, 2'd1, 1'b1}},
    '{'{1'b1, 2'd3, 2'd1, 1'b0}, '{1'b1, 2'd1, 2'd3, 1'b0},
      '{1'b1, 2'd2, 2'd0, 1'b0}, '{1'b1, 2'd0, 2'd2, 1'b1}},
    '{'{1'b1, 2'd3, 2'd2, 1'b0}, '{1'b1, 2'd2, 2'd3, 1'b0},
      '{1'b1, 2'd0, 2'd1, 1'b0}, '{1'b1, 2'd1, 2'd0, 1'b1}},
    '{'{1'b1, 2'd3, 2'd3, 1'b0}, '{1'b1, 2'd0, 2'd0, 1'b1},
      '{1'b1, 2'd1, 2'd1, 1'b1}, '{1'b1, 2'd2, 2'd2, 1'b1}}
  };

endpackage

@@ rtl/vcq_if.sv @@
interface vcq_in_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [2:0]                  kind_a;
  logic [2:0]                  kind_b;
  logic signed [WORD_BITS-1:0] a_x;
  logic signed [WORD_BITS-1:0] a_y;
  logic signed [WORD_BITS-1:0] a_z;
  logic signed [WORD_BITS-1:0] a_w;
  logic signed [WORD_BITS-1:0] b_x;
  logic signed [WORD_BITS-1:0] b_y;
  logic signed [WORD_BITS-1:0] b_z;
  logic signed [WORD_BITS-1:0] b_w;

  modport source (
    output valid, operation, kind_a, kind_b, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
    input  ready
  );
  modport sink (
    input  valid, operation, kind_a, kind_b, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
    output ready
  );
endinterface

interface vcq_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] c_x;
  logic signed [WORD_BITS-1:0] c_y;
  logic signed [WORD_BITS-1:0] c_z;
  logic signed [WORD_BITS-1:0] c_w;
  logic [1:0]                  status;

  modport source (
    output valid, c_x, c_y, c_z, c_w, status,
    input  ready
  );
  modport sink (
    input  valid, c_x, c_y, c_z, c_w, status,
    output ready
  );
endinterface

@@ rtl/vector_complex_quaternion_alu.sv @@
// Complex / vector / quaternion ALU in signed fixed point (WORD_BITS wide, FRAC_BITS
// fraction bits). Fully pipelined: one beat is accepted every cycle while the output is
// not stalled, and the pipe's length is set by the restoring divider, which retires
// one quotient bit per stage; add, sub and mul run
// through the same pipe as a division by one so results stay in order. Four lanes
// compute one result component each (products, then their signed sum), a merge step
// forms the squared norm, and the output stage saturates and folds the lane flags into
// the status. A stalled output only holds the beats behind it until the pipe's bubbles
// are used up.
`include "vector_complex_quaternion_alu_macros.svh"

module vector_complex_quaternion_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  vcq_in_if.sink     in_i,
  vcq_out_if.source  out_o
);
  import vcq_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;
  localparam int SW = PW + 2;
  localparam int NW = SW + FRAC_BITS;
  localparam int DW = PW + 1;
  localparam int QB = W;
  localparam int NS = QB + 2;
  localparam int S  = NS + 3;

  localparam logic signed [W:0] SAT_MAX = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0] SAT_MIN = {2'b11, {(W-1){1'b0}}};

  logic [S-1:0] v_q;
  logic [S-1:0] en;
  logic [S-1:0] v_nxt;

  logic signed [W-1:0] a_in [4];
  logic signed [W-1:0] b_in [4];
  ctrl_t               ctrl_in;
  ctrl_t               ctrl_a_q;
  ctrl_t               ctrl_b_q;
  ctrl_t               ctrl_p_q [NS];
  ctrl_t               ctrl_c;

  logic signed [SW-1:0] sum_b [4];
  logic [PW-1:0]        sq_a  [4];
  logic signed [W-1:0]  b_b   [4];
  logic [DW-1:0]        den_c;
  logic [DW-1:0]        den_q;

  logic [NW-1:0] mag   [4];
  logic [DW-1:0] dvs   [4];
  logic          sgn   [4];
  logic [3:0]    bzero;

  logic [QB-1:0] q_f   [4];
  logic          ovf_f [4];
  logic          neg_f [4];
  logic signed [W-1:0] val_f [4];
  logic [3:0]          sat_f;

  logic signed [W-1:0] c_d [4];
  logic signed [W-1:0] c_q [4];
  logic [1:0]          st_d;
  logic [1:0]          st_q;

  logic out_err;
  logic out_zero;

  // ---------------- handshake and valid pipe ----------------
  for (genvar k = 0; k < S; k++) begin : g_en
    assign en[k] = out_o.ready | ~(&v_q[S-1:k]);
  end

  assign v_nxt       = {v_q[S-2:0], in_i.valid};
  assign in_i.ready  = en[0];
  assign out_o.valid = v_q[S-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < S; k++) begin
        if (en[k]) begin
          v_q[k] <= v_nxt[k];
        end
      end
    end
  end

  // ---------------- decode ----------------
  assign a_in[0] = in_i.a_x;
  assign a_in[1] = in_i.a_y;
  assign a_in[2] = in_i.a_z;
  assign a_in[3] = in_i.a_w;
  assign b_in[0] = in_i.b_x;
  assign b_in[1] = in_i.b_y;
  assign b_in[2] = in_i.b_z;
  assign b_in[3] = in_i.b_w;

  always_comb begin
    ctrl_in.bad = (in_i.kind_a != in_i.kind_b) || (in_i.kind_a > KIND_QUAT);
    ctrl_in.dz  = 1'b0;
    if (in_i.kind_a inside {KIND_CPLX, KIND_VEC2}) begin
      ctrl_in.used = 4'b0011;
    end else if (in_i.kind_a == KIND_VEC3) begin
      ctrl_in.used = 4'b0111;
    end else begin
      ctrl_in.used = 4'b1111;
    end
    ctrl_in.mode = MODE_BAD;
    if (!ctrl_in.bad) begin
      case (in_i.operation)
        OP_ADD: ctrl_in.mode = MODE_ADD;
        OP_SUB: ctrl_in.mode = MODE_SUB;
        OP_MUL: begin
          if (in_i.kind_a == KIND_CPLX) begin
            ctrl_in.mode = MODE_CMUL;
          end else if (in_i.kind_a == KIND_QUAT) begin
            ctrl_in.mode = MODE_QMUL;
          end else begin
            ctrl_in.mode = MODE_VMUL;
          end
        end
        OP_DIV: begin
          if (in_i.kind_a == KIND_CPLX) begin
            ctrl_in.mode = MODE_CDIV;
          end else if (in_i.kind_a == KIND_QUAT) begin
            ctrl_in.mode = MODE_QDIV;
          end else begin
            ctrl_in.mode = MODE_VDIV;
          end
        end
        default: ctrl_in.mode = MODE_BAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ctrl_a_q <= ctrl_in;
    end
    if (en[1]) begin
      ctrl_b_q <= ctrl_a_q;
      den_q    <= den_c;
    end
  end

  // ---------------- lanes ----------------
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vcq_lane #(
      .WORD_BITS (W),
      .LANE      (i)
    ) u_lane (
      .clk_i  (clk_i),
      .en_a_i (en[0]),
      .en_b_i (en[1]),
      .mode_i (ctrl_in.mode),
      .a_i    (a_in),
      .b_i    (b_in),
      .sum_o  (sum_b[i]),
      .sq_o   (sq_a[i]),
      .b_o    (b_b[i])
    );
  end

  // squared norm of b over the used lanes
  always_comb begin
    den_c = '0;
    for (int i = 0; i < LANES; i++) begin
      if (ctrl_a_q.used[i]) begin
        den_c = den_c + DW'(sq_a[i]);
      end
    end
  end

  // ---------------- divider operands ----------------
  for (genvar i = 0; i < LANES; i++) begin : g_prep
    logic signed [SW-1:0] raw_mul;
    logic [SW-1:0]        abs_sum;
    logic [SW-1:0]        abs_mul;
    logic [W-1:0]         babs;

    assign raw_mul  = sum_b[i] >>> FRAC_BITS;
    assign abs_sum  = sum_b[i][SW-1] ? SW'(-sum_b[i]) : SW'(sum_b[i]);
    assign abs_mul  = raw_mul[SW-1] ? SW'(-raw_mul) : SW'(raw_mul);
    assign babs     = b_b[i][W-1] ? (~b_b[i] + W'(1)) : b_b[i];
    assign bzero[i] = (b_b[i] == '0);

    always_comb begin
      mag[i] = '0;
      dvs[i] = DW'(1);
      sgn[i] = 1'b0;
      case (ctrl_b_q.mode)
        MODE_ADD, MODE_SUB: begin
          mag[i] = NW'(abs_sum);
          sgn[i] = sum_b[i][SW-1];
        end
        MODE_CMUL, MODE_VMUL, MODE_QMUL: begin
          mag[i] = NW'(abs_mul);
          sgn[i] = raw_mul[SW-1];
        end
        MODE_CDIV, MODE_QDIV: begin
          mag[i] = NW'(abs_sum) << FRAC_BITS;
          sgn[i] = sum_b[i][SW-1];
          if (den_q != '0) begin
            dvs[i] = den_q;
          end
        end
        MODE_VDIV: begin
          mag[i] = NW'(abs_sum) << FRAC_BITS;
          sgn[i] = sum_b[i][SW-1] ^ b_b[i][W-1];
          if (!bzero[i]) begin
            dvs[i] = DW'(babs);
          end
        end
        default: ;
      endcase
    end

    vcq_div #(
      .NW (NW),
      .DW (DW),
      .QB (QB)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en[NS+1:2]),
      .mag_i (mag[i]),
      .den_i (dvs[i]),
      .neg_i (sgn[i]),
      .q_o   (q_f[i]),
      .ovf_o (ovf_f[i]),
      .neg_o (neg_f[i])
    );
  end

  always_comb begin
    ctrl_c = ctrl_b_q;
    case (ctrl_b_q.mode)
      MODE_CDIV, MODE_QDIV: ctrl_c.dz = (den_q == '0);
      MODE_VDIV:            ctrl_c.dz = |(ctrl_b_q.used & bzero);
      default:              ctrl_c.dz = 1'b0;
    endcase
  end

  // control rides alongside the divider stages
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ctrl_p_q[0] <= ctrl_c;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k+2]) begin
        ctrl_p_q[k] <= ctrl_p_q[k-1];
      end
    end
  end

  // ---------------- sign, saturation, status ----------------
  for (genvar i = 0; i < LANES; i++) begin : g_fin
    logic signed [W:0] qs;

    assign qs = neg_f[i] ? -$signed({1'b0, q_f[i]}) : $signed({1'b0, q_f[i]});

    always_comb begin
      sat_f[i] = 1'b1;
      if (ovf_f[i]) begin
        val_f[i] = neg_f[i] ? SAT_MIN[W-1:0] : SAT_MAX[W-1:0];
      end else if (qs > SAT_MAX) begin
        val_f[i] = SAT_MAX[W-1:0];
      end else if (qs < SAT_MIN) begin
        val_f[i] = SAT_MIN[W-1:0];
      end else begin
        val_f[i] = qs[W-1:0];
        sat_f[i] = 1'b0;
      end
    end
  end

  always_comb begin
    if (ctrl_p_q[NS-1].bad) begin
      st_d = ST_BAD_KIND;
    end else if (ctrl_p_q[NS-1].dz) begin
      st_d = ST_DIV_ZERO;
    end else if (|(ctrl_p_q[NS-1].used & sat_f)) begin
      st_d = ST_SAT;
    end else begin
      st_d = ST_OK;
    end
    for (int i = 0; i < LANES; i++) begin
      c_d[i] = '0;
      if ((st_d == ST_OK || st_d == ST_SAT) && ctrl_p_q[NS-1].used[i]) begin
        c_d[i] = val_f[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S-1]) begin
      c_q  <= c_d;
      st_q <= st_d;
    end
  end

  assign out_o.c_x    = c_q[0];
  assign out_o.c_y    = c_q[1];
  assign out_o.c_z    = c_q[2];
  assign out_o.c_w    = c_q[3];
  assign out_o.status = st_q;

  // ---------------- checks ----------------
  assign out_err  = (out_o.status == ST_BAD_KIND) || (out_o.status == ST_DIV_ZERO);
  assign out_zero = (out_o.c_x == '0) && (out_o.c_y == '0) &&
                    (out_o.c_z == '0) && (out_o.c_w == '0);

  `VCQ_ASSERT_IMP(a_zero_on_error, out_o.valid && out_err, out_zero)
  `VCQ_ASSERT_IMP(a_ready_when_drained, !out_o.valid, in_i.ready)
  `VCQ_ASSERT_NEXT(a_beat_enters_pipe, in_i.valid && in_i.ready, v_q[0])

endmodule

@@ rtl/vcq_lane.sv @@
module vcq_lane #(
  parameter int WORD_BITS = 32,
  parameter int LANE      = 0
) (
  input  logic                          clk_i,
  input  logic                          en_a_i,
  input  logic                          en_b_i,
  input  vcq_pkg::mode_e                mode_i,
  input  logic signed [WORD_BITS-1:0]   a_i [4],
  input  logic signed [WORD_BITS-1:0]   b_i [4],
  output logic signed [2*WORD_BITS+1:0] sum_o,
  output logic [2*WORD_BITS-1:0]        sq_o,
  output logic signed [WORD_BITS-1:0]   b_o
);
  import vcq_pkg::*;

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = PW + 2;
  localparam logic [1:0] LIDX = 2'(LANE);
  localparam logic signed [WORD_BITS-1:0] ONE = WORD_BITS'(1);

  logic signed [WORD_BITS-1:0] x [TERMS];
  logic signed [WORD_BITS-1:0] y [TERMS];
  logic                        ng [TERMS];
  term_t                       tt [TERMS];

  logic signed [PW-1:0]        prod_c [TERMS];
  logic signed [PW-1:0]        prod_q [TERMS];
  logic                        neg_q  [TERMS];
  logic signed [PW-1:0]        sq_c;
  logic signed [PW-1:0]        sq_q;
  logic signed [WORD_BITS-1:0] ba_q;
  logic signed [WORD_BITS-1:0] bb_q;
  logic signed [SW-1:0]        sum_c;
  logic signed [SW-1:0]        sum_q;

  // Term selection: add/sub and vector division use an integer one as the second factor
  always_comb begin
    for (int j = 0; j < TERMS; j++) begin
      x[j]  = '0;
      y[j]  = '0;
      ng[j] = 1'b0;
      tt[j] = T_NONE;
    end
    case (mode_i)
      MODE_ADD, MODE_SUB: begin
        x[0]  = a_i[LIDX];
        y[0]  = ONE;
        x[1]  = b_i[LIDX];
        y[1]  = ONE;
        ng[1] = (mode_i == MODE_SUB);
      end
      MODE_VMUL: begin
        x[0] = a_i[LIDX];
        y[0] = b_i[LIDX];
      end
      MODE_VDIV: begin
        x[0] = a_i[LIDX];
        y[0] = ONE;
      end
      MODE_CMUL, MODE_CDIV, MODE_QMUL, MODE_QDIV: begin
        for (int j = 0; j < TERMS; j++) begin
          if (mode_i == MODE_CMUL) begin
            tt[j] = CMUL_TAB[LIDX][j];
          end else if (mode_i == MODE_CDIV) begin
            tt[j] = CDIV_TAB[LIDX][j];
          end else begin
            tt[j] = HAM_TAB[LIDX][j];
          end
          if (tt[j].used) begin
            x[j]  = a_i[tt[j].ai];
            y[j]  = b_i[tt[j].bi];
            // conjugate of b flips every term on a vector part of b
            ng[j] = tt[j].neg ^ ((mode_i == MODE_QDIV) && (tt[j].bi != 2'd3));
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int j = 0; j < TERMS; j++) begin
      prod_c[j] = x[j] * y[j];
    end
    sq_c = b_i[LIDX] * b_i[LIDX];
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      for (int j = 0; j < TERMS; j++) begin
        prod_q[j] <= prod_c[j];
        neg_q[j]  <= ng[j];
      end
      sq_q <= sq_c;
      ba_q <= b_i[LIDX];
    end
  end

  always_comb begin
    sum_c = '0;
    for (int j = 0; j < TERMS; j++) begin
      if (neg_q[j]) begin
        sum_c = sum_c - {{2{prod_q[j][PW-1]}}, prod_q[j]};
      end else begin
        sum_c = sum_c + {{2{prod_q[j][PW-1]}}, prod_q[j]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      sum_q <= sum_c;
      bb_q  <= ba_q;
    end
  end

  assign sum_o = sum_q;
  assign sq_o  = sq_q;
  assign b_o   = bb_q;

endmodule

@@ rtl/vcq_div.sv @@
module vcq_div #(
  parameter int NW = 82,
  parameter int DW = 65,
  parameter int QB = 32
) (
  input  logic          clk_i,
  input  logic [QB+1:0] en_i,
  input  logic [NW-1:0] mag_i,
  input  logic [DW-1:0] den_i,
  input  logic          neg_i,
  output logic [QB-1:0] q_o,
  output logic          ovf_o,
  output logic          neg_o
);
  localparam int NS = QB + 2;
  localparam int EW = (NW > DW + QB + 1) ? NW : DW + QB + 1;

  logic [NW-1:0] r_q   [NS];
  logic [DW-1:0] d_q   [NS];
  logic [QB-1:0] q_q   [NS];
  logic          neg_q [NS];
  logic          ovf_q [NS];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0]   <= mag_i;
      d_q[0]   <= den_i;
      q_q[0]   <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= 1'b0;
    end
  end

  // Quotient does not fit QB bits: result saturates
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      r_q[1]   <= r_q[0];
      d_q[1]   <= d_q[0];
      q_q[1]   <= q_q[0];
      neg_q[1] <= neg_q[0];
      ovf_q[1] <= EW'(r_q[0]) >= (EW'(d_q[0]) << QB);
    end
  end

  // One restoring step per stage, MSB first
  for (genvar k = 2; k < NS; k++) begin : g_bit
    localparam int BIT = QB + 1 - k;
    logic [EW-1:0] dsh;
    logic          ge;

    assign dsh = EW'(d_q[k-1]) << BIT;
    assign ge  = EW'(r_q[k-1]) >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        r_q[k]   <= ge ? r_q[k-1] - dsh[NW-1:0] : r_q[k-1];
        d_q[k]   <= d_q[k-1];
        q_q[k]   <= q_q[k-1] | (QB'(ge) << BIT);
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q_o   = q_q[NS-1];
  assign ovf_o = ovf_q[NS-1];
  assign neg_o = neg_q[NS-1];

endmodule
